@@ src/crc32w_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32w_pkg
// Shared types and constants for the word-wise MSB-first CRC-32 unit.
// ----------------------------------------------------------------------------
package crc32w_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned WORD_BYTES = WORD_BITS / BYTE_BITS;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [BYTE_BITS-1:0] t_byte;
    typedef t_word [WORD_BITS-1:0] t_cols;

    localparam t_word CRC_POLY   = 32'h04C1_1DB7;
    localparam t_word CRC_INIT   = 32'hFFFF_FFFF;
    localparam t_word CRC_TOPBIT = 32'h8000_0000;
    localparam t_byte MASK_BYTE  = 8'hCD;

    // Remainder after shifting a single set bit through 32 zero data bits.
    function automatic t_word crc_col(input int unsigned bit_idx);
        t_word x;
        x = t_word'(1) << bit_idx;
        for (int unsigned k = 0; k < WORD_BITS; k++) begin
            if ((x & CRC_TOPBIT) != '0) begin
                x = (x << 1) ^ CRC_POLY;
            end else begin
                x = x << 1;
            end
        end
        return x;
    endfunction

    function automatic t_cols crc_cols();
        t_cols c;
        for (int unsigned i = 0; i < WORD_BITS; i++) begin
            c[i] = crc_col(i);
        end
        return c;
    endfunction

    // Column i is the update image of bit i; the fold is linear in crc ^ word.
    localparam t_cols CRC_COLS = crc_cols();

endpackage

@@ src/crc32w_if.sv @@
// ----------------------------------------------------------------------------
// crc32w_in_if / crc32w_out_if
// Valid/ready channels for data words and final CRC values.
// ----------------------------------------------------------------------------
interface crc32w_in_if;
    import crc32w_pkg::*;

    logic  valid;
    logic  ready;
    t_word data_word;
    logic  last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface crc32w_out_if;
    import crc32w_pkg::*;

    logic  valid;
    logic  ready;
    t_word crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

@@ src/crc32w_fold.sv @@
// ----------------------------------------------------------------------------
// crc32w_fold
// One-word CRC-32 update: optional 0xCD byte clearing, then a 32x32 XOR
// matrix applied to crc ^ word.
// ----------------------------------------------------------------------------
module crc32w_fold (
    input  crc32w_pkg::t_word i_crc,
    input  crc32w_pkg::t_word i_word,
    input  logic              i_last,
    output crc32w_pkg::t_word o_crc
);
    import crc32w_pkg::*;

    t_word w_masked;
    t_word w_mix;
    t_word w_acc;

    always_comb begin
        for (int unsigned b = 0; b < WORD_BYTES; b++) begin
            if (i_last && (i_word[b*BYTE_BITS +: BYTE_BITS] == MASK_BYTE)) begin
                w_masked[b*BYTE_BITS +: BYTE_BITS] = '0;
            end else begin
                w_masked[b*BYTE_BITS +: BYTE_BITS] = i_word[b*BYTE_BITS +: BYTE_BITS];
            end
        end
    end

    assign w_mix = i_crc ^ w_masked;

    always_comb begin
        w_acc = '0;
        for (int unsigned i = 0; i < WORD_BITS; i++) begin
            if (w_mix[i]) begin
                w_acc = w_acc ^ CRC_COLS[i];
            end
        end
    end

    assign o_crc = w_acc;

endmodule

@@ src/crc32_word_msb_first_unit.sv @@
// ----------------------------------------------------------------------------
// crc32_word_msb_first_unit
// Running CRC-32 (poly 0x04C11DB7, MSB first, init all ones, no final XOR)
// over 32-bit big-endian words; the final CRC is emitted on the last word.
//
//   channel  dir  payload               transfer
//   i_data   in   data_word, last_word  one word per transfer
//   o_crc    out  crc_value             one per message, after its last word
//
// One word per cycle sustained, unless an output stall holds a last word;
// the accumulator register closes the loop; the final CRC is registered.
// Reset loads all ones into the accumulator and empties both stages.
// An output stall holds a last word in the input stage; other words keep
// folding until a second last word would need the output register.
// ----------------------------------------------------------------------------
module crc32_word_msb_first_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crc32w_in_if.sink    i_data,
    crc32w_out_if.source o_crc
);
    import crc32w_pkg::*;

    logic  r_s1_valid;
    t_word r_s1_word;
    logic  r_s1_last;
    t_word r_crc;
    logic  r_out_valid;
    t_word r_out_crc;

    t_word w_fold;
    logic  w_out_free;
    logic  w_adv;

    crc32w_fold u_fold (
        .i_crc  (r_crc),
        .i_word (r_s1_word),
        .i_last (r_s1_last),
        .o_crc  (w_fold)
    );

    assign w_out_free   = !r_out_valid || o_crc.ready;
    assign w_adv        = r_s1_valid && (!r_s1_last || w_out_free);
    assign i_data.ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_data.ready) begin
            r_s1_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data.ready && i_data.valid) begin
            r_s1_word <= i_data.data_word;
            r_s1_last <= i_data.last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (w_adv) begin
            r_crc <= r_s1_last ? CRC_INIT : w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_crc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_last) begin
            r_out_crc <= w_fold;
        end
    end

    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = r_out_crc;

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_last) |=> (r_crc == CRC_INIT))
        else $error("accumulator not reloaded after last word");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_last) |=> (r_out_valid && (r_out_crc == $past(w_fold))))
        else $error("final CRC not captured");

    a_hold_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_crc == $past(r_crc)))
        else $error("accumulator changed without a folded word");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && !o_crc.ready) |-> !w_adv)
        else $error("last word folded while result register is full");

endmodule
